/* rtl/tss_pkg.sv */
// Shared types and constants of the scriptSig splicer.
// Used by every module of the block; depends on nothing.
package tss_pkg;

  // Capacity of the replacement script store in bytes.
  localparam int SCRIPT_MAX = 128;
  // Script length register width, able to hold SCRIPT_MAX itself.
  localparam int LEN_W = $clog2(SCRIPT_MAX + 1);
  // The store is organized as rows of eight bytes.
  localparam int ROWS = (SCRIPT_MAX + 7) / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Length byte plus script packs into at most this many output words.
  localparam int WORDS_MAX = SCRIPT_MAX / 8 + 1;
  localparam int WIDX_W = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;

  // Input operations.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TX = 2'd2;

  // Final status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_OVER_CAP = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SELECTED_INPUT = 1'b0;
  localparam logic CFG_OUTPUT_CAP = 1'b1;

  // Varint prefixes and the number of bytes that follow each.
  localparam logic [7:0] VI_PFX16 = 8'hfd;
  localparam logic [7:0] VI_PFX32 = 8'hfe;
  localparam logic [3:0] VI_BYTES16 = 4'd2;
  localparam logic [3:0] VI_BYTES32 = 4'd4;
  localparam logic [3:0] VI_BYTES64 = 4'd8;

  // Fixed field lengths of a legacy transaction.
  localparam logic [5:0] VERSION_LAST = 6'd3;
  localparam logic [5:0] OUTPOINT_LAST = 6'd35;
  localparam logic [5:0] SEQUENCE_LAST = 6'd3;

  // Output length tracking saturates just above the largest cap.
  localparam int CAP_W = 24;
  localparam int OLEN_W = CAP_W + 1;
  localparam logic [OLEN_W-1:0] OLEN_SAT = OLEN_W'(1) << CAP_W;

  // One result word.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        run_last;
    logic [1:0]  status;
  } res_t;

  // Request to emit the replacement length byte and script.
  typedef struct packed {
    logic       start;
    logic       run_last;
    logic [1:0] status;
  } rep_cmd_t;

endpackage

/* rtl/tss_script_ram.sv */
// Replacement script store: rows of eight bytes, byte write, registered read.
// Depends on tss_pkg for the geometry.
module tss_script_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [tss_pkg::ROW_W-1:0] wr_row,
  input  logic [2:0]               wr_lane,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [tss_pkg::ROW_W-1:0] rd_row,
  output logic [63:0]              rd_data
);

  logic [63:0] mem_r [tss_pkg::ROWS];
  logic [63:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tss_out_queue.sv */
// Two-word result queue between the splicer logic and the output channel.
// Depends on tss_pkg for the result word type.
module tss_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tss_pkg::res_t push_data,
  output logic          full,
  input  logic          pop_ready,
  output logic          head_valid,
  output tss_pkg::res_t head
);

  tss_pkg::res_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       pop;

  assign head_valid = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'd2);
  assign head = ent_r[rd_ptr_r];
  assign pop = head_valid & pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/tss_replay.sv */
// Replays the length byte and the stored script as packed eight-byte words.
// Depends on tss_pkg; reads one store row per cycle while the queue has room.
module tss_replay (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tss_pkg::rep_cmd_t           cmd,
  input  logic [tss_pkg::LEN_W-1:0]   store_len,
  input  logic                        q_full,
  input  logic [63:0]                 rd_data,
  output logic                        rd_en,
  output logic [tss_pkg::ROW_W-1:0]   rd_row,
  output logic                        busy,
  output logic                        push,
  output tss_pkg::res_t               push_res
);

  logic                        busy_r;
  logic [tss_pkg::WIDX_W-1:0]  k_r;
  logic [tss_pkg::WIDX_W-1:0]  k_inc;
  logic [tss_pkg::WIDX_W-1:0]  last_k;
  logic [7:0]                  prev_r;
  logic                        last_r;
  logic [1:0]                  status_r;
  logic                        at_last;
  logic [3:0]                  cnt;
  logic [7:0]                  src;

  // Word k carries sequence bytes 8k..8k+7, where byte 0 is the length and
  // byte i is script byte i-1: the top byte of row k-1 and bytes 0..6 of row k.
  assign last_k = tss_pkg::WIDX_W'(store_len >> 3);
  assign at_last = (k_r == last_k);
  assign k_inc = k_r + tss_pkg::WIDX_W'(1);

  assign busy = busy_r;
  assign push = busy_r & ~q_full;
  assign rd_en = cmd.start | (push & ~at_last);
  assign rd_row = cmd.start ? '0 : tss_pkg::ROW_W'(k_inc);

  always_comb begin
    cnt = at_last ? ({1'b0, store_len[2:0]} + 4'd1) : 4'd8;
    push_res.bytes = '0;
    src = (k_r == '0) ? 8'(store_len) : prev_r;
    if (cnt != 4'd0) begin
      push_res.bytes[7:0] = src;
    end
    for (int j = 1; j < 8; j++) begin
      if (4'(j) < cnt) begin
        push_res.bytes[j*8 +: 8] = rd_data[(j-1)*8 +: 8];
      end
    end
    push_res.count = cnt;
    push_res.run_last = at_last & last_r;
    push_res.status = (at_last & last_r) ? status_r : tss_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
    end else if (push && at_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k_r <= '0;
      last_r <= cmd.run_last;
      status_r <= cmd.status;
    end else if (push && !at_last) begin
      k_r <= k_inc;
      prev_r <= rd_data[63:56];
    end
  end

endmodule

/* rtl/tx_scriptsig_splicer.sv */
// Top level of the legacy transaction scriptSig splicer.
// Depends on tss_pkg, tss_script_ram, tss_replay and tss_out_queue.
//
// The block takes a legacy transaction one byte per word and passes it on
// with the scriptSig of the input chosen by selected_input replaced by a
// script that was loaded earlier with append words (clear words empty it;
// appends past the store capacity are dropped). Version, input count,
// outpoints, sequences and everything after the inputs are copied one byte
// per result word with a count of one. For the selected input the original
// script length and script are swallowed, and the new length byte followed
// by the stored script comes out packed eight bytes per word, first byte in
// the low bits. The last word of a transaction carries run_last and a status:
// malformed when the final byte did not lie after the inputs, over cap when
// the rewritten length exceeds output_cap, otherwise ok. A final byte that
// produces no bytes still yields one empty word to carry the status.
// Copy, clear and append words are taken one per cycle unless a replay runs
// or the queue is full. A splice holds off the input until its replay ends;
// the store is read one eight-byte row per cycle while the queue has room. A
// two-word queue decouples the output, so input keeps flowing while a result
// waits to be taken. The script store is not cleared after reset; it needs no
// clearing pass, since only bytes that were appended are read.
// Configuration writes are meant to happen while no transaction is in flight.
module tx_scriptsig_splicer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_tx_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        out_run_last,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  // Parser phases.
  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_OUTPOINT = 3'd2;
  localparam logic [2:0] PH_SLEN = 3'd3;
  localparam logic [2:0] PH_SCRIPT = 3'd4;
  localparam logic [2:0] PH_SEQ = 3'd5;
  localparam logic [2:0] PH_REST = 3'd6;

  // Configuration registers.
  logic [15:0]                 sel_input_r;
  logic [tss_pkg::CAP_W-1:0]   cap_r;

  // Script store bookkeeping.
  logic [tss_pkg::LEN_W-1:0]   slen_r, slen_nxt;

  // Parser state.
  logic [2:0]                  phase_r, phase_nxt;
  logic [5:0]                  fc_r, fc_nxt;
  logic [63:0]                 vv_r, vv_nxt;
  logic [3:0]                  vrem_r, vrem_nxt;
  logic [31:0]                 in_num_r, in_num_nxt;
  logic [31:0]                 in_tot_r, in_tot_nxt;
  logic [tss_pkg::OLEN_W-1:0]  olen_r, olen_nxt;

  // Handshake and decode.
  logic                        accept;
  logic                        acc_tx;
  logic                        acc_append;
  logic                        rep_busy;
  logic                        q_full;

  // Varint decoder outputs.
  logic                        vi_done;
  logic [63:0]                 vi_val;
  logic [3:0]                  vi_rem;
  logic [5:0]                  vi_fc;

  logic                        sel;
  logic                        copy;
  logic                        repl;
  logic [8:0]                  add_len;
  logic [tss_pkg::OLEN_W-1:0]  olen_sum;
  logic [tss_pkg::OLEN_W-1:0]  olen_sat;
  logic [1:0]                  status;

  // Result paths.
  logic                        par_push;
  tss_pkg::res_t               par_res;
  tss_pkg::rep_cmd_t           rep_cmd;
  logic                        rep_push;
  tss_pkg::res_t               rep_res;
  logic                        q_push;
  tss_pkg::res_t               q_data;
  tss_pkg::res_t               q_head;

  // Script store ports.
  logic                        ram_wr_en;
  logic                        ram_rd_en;
  logic [tss_pkg::ROW_W-1:0]   ram_rd_row;
  logic [63:0]                 ram_rd_data;

  // Nothing is taken while the script is being replayed or the queue is full.
  assign in_ready = ~rep_busy & ~q_full;
  assign accept = in_valid & in_ready;
  assign acc_tx = accept & (in_operation == tss_pkg::OP_TX);
  assign acc_append = accept & (in_operation == tss_pkg::OP_APPEND);

  // Appends past the store capacity are ignored.
  assign ram_wr_en = acc_append & (slen_r < tss_pkg::LEN_W'(tss_pkg::SCRIPT_MAX));

  always_comb begin
    slen_nxt = slen_r;
    if (accept && in_operation == tss_pkg::OP_CLEAR) begin
      slen_nxt = '0;
    end else if (ram_wr_en) begin
      slen_nxt = slen_r + tss_pkg::LEN_W'(1);
    end
  end

  // Varint decoder: a byte below 0xfd is the value itself; the prefixes
  // announce 2, 4 or 8 little-endian bytes that follow.
  always_comb begin
    vi_done = 1'b0;
    vi_val = vv_r;
    vi_rem = vrem_r;
    vi_fc = fc_r;
    if (vrem_r == 4'd0) begin
      if (in_data_byte < tss_pkg::VI_PFX16) begin
        vi_val = {56'd0, in_data_byte};
        vi_done = 1'b1;
      end else begin
        vi_val = '0;
        vi_fc = '0;
        if (in_data_byte == tss_pkg::VI_PFX16) begin
          vi_rem = tss_pkg::VI_BYTES16;
        end else if (in_data_byte == tss_pkg::VI_PFX32) begin
          vi_rem = tss_pkg::VI_BYTES32;
        end else begin
          vi_rem = tss_pkg::VI_BYTES64;
        end
      end
    end else begin
      for (int j = 0; j < 8; j++) begin
        if (fc_r[2:0] == 3'(j)) begin
          vi_val[j*8 +: 8] = vv_r[j*8 +: 8] | in_data_byte;
        end
      end
      vi_fc = fc_r + 6'd1;
      vi_rem = vrem_r - 4'd1;
      if (vrem_r == 4'd1) begin
        vi_done = 1'b1;
        vi_fc = '0;
      end
    end
  end

  assign sel = (in_num_r == {16'd0, sel_input_r});

  // Transaction parser: decides whether the byte is copied, dropped, or
  // closes the selected input's script and starts the replay.
  always_comb begin
    phase_nxt = phase_r;
    fc_nxt = fc_r;
    vv_nxt = vv_r;
    vrem_nxt = vrem_r;
    in_num_nxt = in_num_r;
    in_tot_nxt = in_tot_r;
    copy = 1'b0;
    repl = 1'b0;
    case (phase_r)
      PH_VERSION: begin
        copy = 1'b1;
        if (fc_r == tss_pkg::VERSION_LAST) begin
          fc_nxt = '0;
          phase_nxt = PH_COUNT;
        end else begin
          fc_nxt = fc_r + 6'd1;
        end
      end
      PH_COUNT: begin
        copy = 1'b1;
        vv_nxt = vi_val;
        vrem_nxt = vi_rem;
        fc_nxt = vi_fc;
        if (vi_done) begin
          // Counts that do not fit 32 bits saturate.
          in_tot_nxt = (vi_val[63:32] != 32'd0) ? 32'hffff_ffff : vi_val[31:0];
          in_num_nxt = '0;
          fc_nxt = '0;
          phase_nxt = (in_tot_nxt != 32'd0) ? PH_OUTPOINT : PH_REST;
        end
      end
      PH_OUTPOINT: begin
        copy = 1'b1;
        if (fc_r == tss_pkg::OUTPOINT_LAST) begin
          fc_nxt = '0;
          phase_nxt = PH_SLEN;
        end else begin
          fc_nxt = fc_r + 6'd1;
        end
      end
      PH_SLEN: begin
        copy = ~sel;
        vv_nxt = vi_val;
        vrem_nxt = vi_rem;
        fc_nxt = vi_fc;
        if (vi_done) begin
          if (vi_val == 64'd0) begin
            repl = sel;
            phase_nxt = PH_SEQ;
            fc_nxt = '0;
          end else begin
            phase_nxt = PH_SCRIPT;
          end
        end
      end
      PH_SCRIPT: begin
        copy = ~sel;
        vv_nxt = vv_r - 64'd1;
        if (vv_nxt == 64'd0) begin
          repl = sel;
          phase_nxt = PH_SEQ;
          fc_nxt = '0;
        end
      end
      PH_SEQ: begin
        copy = 1'b1;
        if (fc_r == tss_pkg::SEQUENCE_LAST) begin
          fc_nxt = '0;
          in_num_nxt = in_num_r + 32'd1;
          phase_nxt = (in_num_nxt >= in_tot_r) ? PH_REST : PH_OUTPOINT;
        end else begin
          fc_nxt = fc_r + 6'd1;
        end
      end
      default: begin
        copy = 1'b1;
      end
    endcase
  end

  // Output length after this byte, saturating just above any cap value.
  always_comb begin
    if (copy) begin
      add_len = 9'd1;
    end else if (repl) begin
      add_len = 9'(slen_r) + 9'd1;
    end else begin
      add_len = 9'd0;
    end
    olen_sum = olen_r + tss_pkg::OLEN_W'(add_len);
    olen_sat = (olen_sum > tss_pkg::OLEN_SAT) ? tss_pkg::OLEN_SAT : olen_sum;
    if (phase_r != PH_REST) begin
      status = tss_pkg::ST_MALFORMED;
    end else if (olen_sat > {1'b0, cap_r}) begin
      status = tss_pkg::ST_OVER_CAP;
    end else begin
      status = tss_pkg::ST_OK;
    end
  end

  assign olen_nxt = olen_sat;

  // A copied byte or an empty closing word goes straight to the queue; the
  // replacement goes through the replay unit.
  always_comb begin
    par_push = acc_tx & (copy | (~repl & in_tx_end));
    par_res.bytes = copy ? {56'd0, in_data_byte} : 64'd0;
    par_res.count = copy ? 4'd1 : 4'd0;
    par_res.run_last = in_tx_end;
    par_res.status = in_tx_end ? status : tss_pkg::ST_OK;
    rep_cmd.start = acc_tx & repl;
    rep_cmd.run_last = in_tx_end;
    rep_cmd.status = status;
  end

  assign q_push = par_push | rep_push;
  assign q_data = rep_push ? rep_res : par_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_input_r <= '0;
      cap_r <= {tss_pkg::CAP_W{1'b1}};
      slen_r <= '0;
      phase_r <= PH_VERSION;
      fc_r <= '0;
      vv_r <= '0;
      vrem_r <= '0;
      in_num_r <= '0;
      in_tot_r <= '0;
      olen_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tss_pkg::CFG_SELECTED_INPUT: sel_input_r <= cfg_data[15:0];
          tss_pkg::CFG_OUTPUT_CAP: cap_r <= cfg_data;
          default: ;
        endcase
      end
      slen_r <= slen_nxt;
      if (acc_tx) begin
        if (in_tx_end) begin
          // The parser starts over; the stored script and registers stay.
          phase_r <= PH_VERSION;
          fc_r <= '0;
          vv_r <= '0;
          vrem_r <= '0;
          in_num_r <= '0;
          in_tot_r <= '0;
          olen_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          fc_r <= fc_nxt;
          vv_r <= vv_nxt;
          vrem_r <= vrem_nxt;
          in_num_r <= in_num_nxt;
          in_tot_r <= in_tot_nxt;
          olen_r <= olen_nxt;
        end
      end
    end
  end

  tss_script_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_row  (tss_pkg::ROW_W'(slen_r >> 3)),
    .wr_lane (slen_r[2:0]),
    .wr_data (in_data_byte),
    .rd_en   (ram_rd_en),
    .rd_row  (ram_rd_row),
    .rd_data (ram_rd_data)
  );

  tss_replay u_replay (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (rep_cmd),
    .store_len  (slen_r),
    .q_full     (q_full),
    .rd_data    (ram_rd_data),
    .rd_en      (ram_rd_en),
    .rd_row     (ram_rd_row),
    .busy       (rep_busy),
    .push       (rep_push),
    .push_res   (rep_res)
  );

  tss_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (q_head)
  );

  assign out_bytes = q_head.bytes;
  assign out_count = q_head.count;
  assign out_run_last = q_head.run_last;
  assign out_status = q_head.status;

endmodule

/* dv/tx_scriptsig_splicer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the legacy transaction scriptSig splicer.
// Depends on tss_pkg and the tx_scriptsig_splicer RTL; nothing else is read.
module tx_scriptsig_splicer_tb;
  import tss_pkg::*;

  // Cycle budget of the whole run. The slowest correct run (every word held
  // off, every result stalled for the longest wait) stays far below it.
  localparam int LIMIT = 600000;
  // Quiet cycles after the last expected word: a splice holds the input until
  // its whole script is replayed and the output queue is two words deep.
  localparam int SETTLE = 40;
  // Random words to feed after the directed part.
  localparam int RANDOM_WORDS = 330;
  // The one operation code the block must ignore.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  // Prefix of the eight-byte varint form.
  localparam logic [7:0] VI_PFX64 = 8'hff;

  // Where the parser stands within a transaction.
  typedef enum logic [2:0] {
    F_VERSION,
    F_COUNT,
    F_OUTPOINT,
    F_SCRIPT_LEN,
    F_SCRIPT,
    F_SEQUENCE,
    F_TAIL
  } tx_field_e;

  // One word of the input channel.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       tx_end;
  } tx_word_t;

  // Every input of the block holds a known value from time zero on.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_CLEAR;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_tx_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        out_run_last;
  logic [1:0]  out_status;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_SELECTED_INPUT;
  logic [23:0] cfg_data = 24'h0;

  // Shadow of the splicer: stored script, parser state and registers.
  logic [7:0]  script_mem [SCRIPT_MAX];
  int unsigned script_fill = 0;
  tx_field_e   field = F_VERSION;
  logic [31:0] field_pos = 32'd0;
  logic [63:0] vi_value = 64'd0;
  int unsigned vi_left = 0;
  logic [31:0] input_idx = 32'd0;
  logic [31:0] input_cnt = 32'd0;
  logic [31:0] rewritten_len = 32'd0;
  logic [15:0] sel_input = 16'd0;
  logic [23:0] len_cap = 24'hff_ffff;

  // Words still to be driven, words predicted but not yet seen, and the
  // words that the current input word causes.
  tx_word_t    pending_words [$];
  res_t        expected_words [$];
  res_t        step_words [$];
  // Scratch buffer in which a transaction is assembled before it is queued.
  logic [7:0]  tx_bytes [$];

  tx_word_t    cur_word;
  int          in_gap = 0;
  bit          in_calm = 1'b0;
  int          out_stall = 0;
  bit          out_calm = 1'b0;
  res_t        got_word;
  int          mismatches = 0;
  int          words_fed = 0;
  int          cycle_no = 0;

  tx_scriptsig_splicer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_tx_end    (in_tx_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bytes    (out_bytes),
    .out_count    (out_count),
    .out_run_last (out_run_last),
    .out_status   (out_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Appends one result word of this step and keeps the saturating count of
  // rewritten bytes up to date.
  function automatic void emit(logic [63:0] bytes, logic [3:0] cnt);
    res_t r;
    r.bytes = bytes;
    r.count = cnt;
    r.run_last = 1'b0;
    r.status = ST_OK;
    step_words.push_back(r);
    if (32'(cnt) > 32'hffff_ffff - rewritten_len) rewritten_len = 32'hffff_ffff;
    else rewritten_len = rewritten_len + 32'(cnt);
  endfunction

  // Takes one varint byte; returns 1 once the value is complete in vi_value.
  // The field position doubles as the byte index inside a long varint.
  function automatic bit varint_done(logic [7:0] b);
    if (vi_left == 0) begin
      if (b < VI_PFX16) begin
        vi_value = 64'(b);
        return 1'b1;
      end
      vi_value = 64'd0;
      field_pos = 32'd0;
      vi_left = int'((b == VI_PFX16) ? VI_BYTES16 : (b == VI_PFX32) ? VI_BYTES32 : VI_BYTES64);
      return 1'b0;
    end
    vi_value = vi_value | (64'(b) << ((8 * field_pos) & 32'd63));
    field_pos = field_pos + 1;
    vi_left = vi_left - 1;
    if (vi_left == 0) begin
      field_pos = 32'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // End of a scriptSig. For the selected input the new length byte and the
  // stored script go out here, eight bytes per word, first byte lowest.
  function automatic void close_script(bit sel);
    logic [63:0] acc;
    int          n;
    logic [7:0]  v;
    if (sel) begin
      acc = 64'd0;
      n = 0;
      for (int i = 0; i <= int'(script_fill); i++) begin
        v = (i == 0) ? 8'(script_fill) : script_mem[i-1];
        acc = acc | (64'(v) << (8 * n));
        n++;
        if (n == 8) begin
          emit(acc, 4'd8);
          acc = 64'd0;
          n = 0;
        end
      end
      if (n != 0) emit(acc, 4'(n));
    end
    field = F_SEQUENCE;
    field_pos = 32'd0;
  endfunction

  // Works out the result words of one accepted input word and queues them.
  function automatic void predict_splice(tx_word_t w);
    tx_field_e  arrive;
    bit         sel;
    logic [1:0] st;
    step_words.delete();
    if (w.op == OP_CLEAR) begin
      script_fill = 0;
      return;
    end
    if (w.op == OP_APPEND) begin
      // A full store drops further appends.
      if (script_fill < SCRIPT_MAX) begin
        script_mem[script_fill] = w.data;
        script_fill++;
      end
      return;
    end
    if (w.op == OP_IGNORED) return;

    arrive = field;
    sel = (input_idx == {16'd0, sel_input});
    case (field)
      F_VERSION: begin
        emit(64'(w.data), 4'd1);
        if (field_pos == 32'(VERSION_LAST)) begin
          field_pos = 32'd0;
          field = F_COUNT;
        end else field_pos = field_pos + 1;
      end
      F_COUNT: begin
        emit(64'(w.data), 4'd1);
        if (varint_done(w.data)) begin
          // Counts beyond 32 bits saturate.
          input_cnt = (vi_value > 64'hffff_ffff) ? 32'hffff_ffff : vi_value[31:0];
          input_idx = 32'd0;
          field_pos = 32'd0;
          field = (input_cnt != 0) ? F_OUTPOINT : F_TAIL;
        end
      end
      F_OUTPOINT: begin
        emit(64'(w.data), 4'd1);
        if (field_pos == 32'(OUTPOINT_LAST)) begin
          field_pos = 32'd0;
          field = F_SCRIPT_LEN;
        end else field_pos = field_pos + 1;
      end
      F_SCRIPT_LEN: begin
        // The selected input's own length varint is swallowed.
        if (!sel) emit(64'(w.data), 4'd1);
        if (varint_done(w.data)) begin
          if (vi_value == 0) close_script(sel);
          else field = F_SCRIPT;
        end
      end
      F_SCRIPT: begin
        if (!sel) emit(64'(w.data), 4'd1);
        vi_value = vi_value - 1;
        if (vi_value == 0) close_script(sel);
      end
      F_SEQUENCE: begin
        emit(64'(w.data), 4'd1);
        if (field_pos == 32'(SEQUENCE_LAST)) begin
          field_pos = 32'd0;
          input_idx = input_idx + 1;
          field = (input_idx >= input_cnt) ? F_TAIL : F_OUTPOINT;
        end else field_pos = field_pos + 1;
      end
      default: emit(64'(w.data), 4'd1);
    endcase

    if (w.tx_end) begin
      // Ending anywhere but after the inputs is malformed, and that wins
      // over the length cap.
      if (arrive != F_TAIL) st = ST_MALFORMED;
      else if (rewritten_len > 32'(len_cap)) st = ST_OVER_CAP;
      else st = ST_OK;
      // A dropped final byte still yields an empty word to carry the status.
      if (step_words.size() == 0) emit(64'd0, 4'd0);
      step_words[step_words.size()-1].run_last = 1'b1;
      step_words[step_words.size()-1].status = st;
      field = F_VERSION;
      field_pos = 32'd0;
      vi_value = 64'd0;
      vi_left = 0;
      input_idx = 32'd0;
      input_cnt = 32'd0;
      rewritten_len = 32'd0;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: takes words from pending_words, holds each until it is
  // accepted, then waits a randomly drawn gap before the next one. Now and
  // then it switches into a calm stretch in which it never waits.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_splice(cur_word);
      if (in_valid && !in_ready) begin
        // Still waiting for the block: the word stays as it is.
      end else if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_operation <= cur_word.op;
        in_data_byte <= cur_word.data;
        in_tx_end <= cur_word.tx_end;
        in_valid <= 1'b1;
        if ($urandom_range(15) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: checks every accepted word against the oldest
  // expectation and stalls for a randomly drawn gap after each one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_word.bytes = out_bytes;
        got_word.count = out_count;
        got_word.run_last = out_run_last;
        got_word.status = out_status;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: bytes=%h count=%0d last=%b status=%0d",
                     got_word.bytes, got_word.count, got_word.run_last, got_word.status);
        end else if (got_word.bytes !== expected_words[0].bytes ||
                     got_word.count !== expected_words[0].count ||
                     got_word.run_last !== expected_words[0].run_last ||
                     got_word.status !== expected_words[0].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected bytes=%h count=%0d last=%b status=%0d, %s%h %s%0d %s%b %s%0d",
                     expected_words[0].bytes, expected_words[0].count,
                     expected_words[0].run_last, expected_words[0].status,
                     "got bytes=", got_word.bytes, "count=", got_word.count,
                     "last=", got_word.run_last, "status=", got_word.status);
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
        if ($urandom_range(15) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(9);
      end
      if (out_stall != 0) begin
        out_stall = out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Queues one input word. Ignored operations do not count as fed words.
  task automatic push_word(logic [1:0] op, logic [7:0] data, logic last);
    tx_word_t w;
    w.op = op;
    w.data = data;
    w.tx_end = last;
    pending_words.push_back(w);
    if (op != OP_IGNORED) words_fed++;
  endtask

  // Writes one register while the block is idle and updates the shadow copy.
  task automatic write_reg(logic idx, logic [23:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_SELECTED_INPUT) sel_input = val[15:0];
    else len_cap = val;
    @(negedge clk);
  endtask

  // Waits until every queued word went in and every expected word came out,
  // then lets the block settle. Checked at the falling edge, away from the
  // clocked processes.
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Clears the stored script and appends n random bytes; tx_end is noise.
  task automatic load_script(int n);
    push_word(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (n) push_word(OP_APPEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Varint into tx_bytes; mostly the short form, sometimes a longer one,
  // which the block must accept even when it is not minimal.
  task automatic add_varint(logic [63:0] v);
    int nb;
    if (v < 64'(VI_PFX16) && $urandom_range(7) != 0) begin
      tx_bytes.push_back(v[7:0]);
      return;
    end
    case ($urandom_range(2))
      0: begin
        tx_bytes.push_back(VI_PFX16);
        nb = int'(VI_BYTES16);
      end
      1: begin
        tx_bytes.push_back(VI_PFX32);
        nb = int'(VI_BYTES32);
      end
      default: begin
        tx_bytes.push_back(VI_PFX64);
        nb = int'(VI_BYTES64);
      end
    endcase
    for (int k = 0; k < nb; k++) tx_bytes.push_back(v[8*k +: 8]);
  endtask

  // Queues one transaction with n_in inputs of random content. cut_len of 0
  // keeps it whole, a negative one cuts it at a random length, a positive
  // one cuts it there. A huge one claims a count beyond 32 bits and ends
  // right after its inputs. A stray ignored or append word slips in now and
  // then.
  task automatic queue_tx(int n_in, int cut_len, bit huge);
    int slen;
    int keep;
    tx_bytes.delete();
    repeat (int'(VERSION_LAST) + 1) tx_bytes.push_back(8'($urandom_range(255)));
    if (huge) begin
      tx_bytes.push_back(VI_PFX64);
      repeat (7) tx_bytes.push_back(8'($urandom_range(255)));
      tx_bytes.push_back(8'($urandom_range(1, 255)));
    end else add_varint(64'(n_in));
    for (int k = 0; k < n_in; k++) begin
      repeat (int'(OUTPOINT_LAST) + 1) tx_bytes.push_back(8'($urandom_range(255)));
      slen = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12);
      add_varint(64'(slen));
      repeat (slen) tx_bytes.push_back(8'($urandom_range(255)));
      repeat (int'(SEQUENCE_LAST) + 1) tx_bytes.push_back(8'($urandom_range(255)));
    end
    // Outputs and lock time are opaque here; an empty tail means the
    // transaction ends right after its inputs, which counts as malformed.
    if (!huge) repeat ($urandom_range(14)) tx_bytes.push_back(8'($urandom_range(255)));
    keep = tx_bytes.size();
    if (cut_len < 0) keep = $urandom_range(1, keep);
    else if (cut_len > 0 && cut_len < keep) keep = cut_len;
    for (int k = 0; k < keep; k++) begin
      if ($urandom_range(39) == 0)
        push_word($urandom_range(1) ? OP_IGNORED : OP_APPEND,
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      push_word(OP_TX, tx_bytes[k], k == keep - 1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int phase_no;
    int n_in;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(CFG_SELECTED_INPUT, 24'd0);
    write_reg(CFG_OUTPUT_CAP, 24'hff_ffff);

    // Directed: every operation, all but clear with both tx_end values,
    // extreme bytes, the ignored code, and transactions that end early.
    push_word(OP_CLEAR, 8'h5a, 1'b1);
    push_word(OP_APPEND, 8'hff, 1'b1);
    push_word(OP_APPEND, 8'h00, 1'b0);
    push_word(OP_IGNORED, 8'hff, 1'b1);
    push_word(OP_IGNORED, 8'h00, 1'b0);
    // Version field cut short.
    push_word(OP_TX, 8'h00, 1'b0);
    push_word(OP_TX, 8'hff, 1'b0);
    push_word(OP_TX, 8'h7f, 1'b1);
    // No inputs and one trailing byte: a clean end.
    push_word(OP_TX, 8'h01, 1'b0);
    repeat (3) push_word(OP_TX, 8'h00, 1'b0);
    push_word(OP_TX, 8'h00, 1'b0);
    push_word(OP_TX, 8'hff, 1'b1);
    // No inputs and nothing after the count: malformed.
    push_word(OP_TX, 8'h02, 1'b0);
    repeat (3) push_word(OP_TX, 8'h00, 1'b0);
    push_word(OP_TX, 8'h00, 1'b1);
    drain();

    // Random part in phases. Each phase ends with the sender paused until
    // every expected word is back, so registers change only while idle.
    words_fed = 0;
    phase_no = 0;
    while (words_fed < RANDOM_WORDS) begin
      case (phase_no)
        0: begin
          // Cap of zero, empty script: the splice is just a zero length
          // byte. The second one is cut after 43 bytes; where that lies
          // in the swallowed script, its final byte produces nothing.
          write_reg(CFG_SELECTED_INPUT, 24'd0);
          write_reg(CFG_OUTPUT_CAP, 24'd0);
          load_script(0);
          queue_tx(1, 0, 1'b0);
          queue_tx(1, 43, 1'b0);
        end
        1: begin
          // Appends past capacity are dropped; the splice is the longest.
          write_reg(CFG_SELECTED_INPUT, 24'd1);
          write_reg(CFG_OUTPUT_CAP, 24'hff_ffff);
          load_script(SCRIPT_MAX + 2);
          queue_tx(2, 0, 1'b0);
        end
        2: begin
          // Selection far out of range: copied unchanged.
          write_reg(CFG_SELECTED_INPUT, 24'h00_ffff);
          write_reg(CFG_OUTPUT_CAP, 24'($urandom_range(60, 250)));
          queue_tx(1, 0, 1'b1);
          queue_tx(2, 0, 1'b0);
        end
        default: begin
          write_reg(CFG_SELECTED_INPUT, ($urandom_range(3) == 0) ?
                    24'($urandom_range(65535)) : 24'($urandom_range(3)));
          case ($urandom_range(2))
            0: write_reg(CFG_OUTPUT_CAP, 24'hff_ffff);
            1: write_reg(CFG_OUTPUT_CAP, 24'($urandom_range(40, 200)));
            default: write_reg(CFG_OUTPUT_CAP, 24'($urandom_range(24'hff_ffff)));
          endcase
          if ($urandom_range(1) != 0) load_script($urandom_range(20));
          repeat ($urandom_range(1, 2)) begin
            n_in = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(1, 2);
            queue_tx(n_in, ($urandom_range(3) == 0) ? -1 : 0, $urandom_range(15) == 0);
          end
        end
      endcase
      drain();
      phase_no++;
    end

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
